### src/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants of the rate monotonic task scheduler.
// ----------------------------------------------------------------------------
package rms_pkg;

	// Default sizes and fixed field widths
	localparam int NUM_SLOTS_DEF = 32;
	localparam int TIME_BITS_DEF = 16;
	localparam int CMD_W         = 3;
	localparam int SLOT_W        = 5;
	localparam int TIME_IN_W     = 16;
	localparam int PRIO_W        = 6;
	localparam int TICK_W        = 32;
	localparam int CNT_W         = 5;
	localparam int IDLE_BUDGET   = 5000;

	// Command codes of an input transaction
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_CREATE = 3'd1,
		CMD_FINISH = 3'd2,
		CMD_LOCK   = 3'd3,
		CMD_UNLOCK = 3'd4
	} cmd_code_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SCAN,
		OP_DECIDE,
		OP_DIV,
		OP_CREATE,
		OP_FINISH,
		OP_LOCK,
		OP_UNLOCK,
		OP_COMMIT
	} dp_op_t;

	typedef struct packed {
		logic             capture;
		dp_op_t           op;
		logic             wake;
		logic             scan_first;
		logic [CNT_W-1:0] cnt;
		logic             publish;
	} dp_cmd_t;

	typedef struct packed {
		logic repick;
		logic cur_runnable;
	} dp_stat_t;

endpackage

### src/rms_req_if.sv
// ----------------------------------------------------------------------------
// rms_req_if
// Request channel: one scheduler command per transaction.
// ----------------------------------------------------------------------------
interface rms_req_if import rms_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     cmd;
	logic [SLOT_W-1:0]    slot;
	logic [TIME_IN_W-1:0] budget;
	logic [TIME_IN_W-1:0] period;
	logic [PRIO_W-1:0]    ceiling;

	modport source (output valid, cmd, slot, budget, period, ceiling, input ready);
	modport sink (input valid, cmd, slot, budget, period, ceiling, output ready);
endinterface

### src/rms_rsp_if.sv
// ----------------------------------------------------------------------------
// rms_rsp_if
// Response channel: switch flag and running slot per transaction.
// ----------------------------------------------------------------------------
interface rms_rsp_if import rms_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              switch_needed;
	logic [SLOT_W-1:0] running_slot;

	modport source (output valid, switch_needed, running_slot, input ready);
	modport sink (input valid, switch_needed, running_slot, output ready);
endinterface

### src/rms_ctrl.sv
// ----------------------------------------------------------------------------
// rms_ctrl
// Sequencer of the scheduler: slot scans, decision, divider steps, publish.
// ----------------------------------------------------------------------------
module rms_ctrl import rms_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [CMD_W-1:0]  in_cmd,
	input  logic [SLOT_W-1:0] in_slot,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dp_cmd_t           cmd,
	input  dp_stat_t          stat
);
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(TICK_W - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_RESCAN, S_COMMIT, S_DIV, S_CREATE, S_EXEC, S_PUB
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CMD_W-1:0]   code_q;
	logic               out_valid_q;
	logic               out_free;
	logic               create_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign create_ok = in_slot < SLOT_W'(NUM_SLOTS - 1);

	// State, counter and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			code_q      <= CMD_TICK;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the response on publish, drop it once taken
			if (state_q == S_PUB && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						code_q <= in_cmd;
						cnt_q  <= '0;
						case (in_cmd)
							CMD_TICK:   state_q <= S_SCAN;
							CMD_CREATE: state_q <= create_ok ? S_DIV : S_PUB;
							CMD_FINISH: state_q <= S_EXEC;
							CMD_LOCK:   state_q <= S_EXEC;
							CMD_UNLOCK: state_q <= S_EXEC;
							default:    state_q <= S_PUB;
						endcase
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DECIDE: state_q <= stat.repick ? S_RESCAN : S_PUB;
				S_RESCAN: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_COMMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_COMMIT: state_q <= S_PUB;
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_DIV)
						state_q <= S_CREATE;
				end
				S_CREATE: state_q <= S_PUB;
				S_EXEC:   state_q <= S_PUB;
				S_PUB: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decode state into datapath commands
	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.capture    = in_valid && (state_q == S_IDLE);
		cmd.cnt        = cnt_q;
		cmd.scan_first = (cnt_q == '0);
		cmd.publish    = (state_q == S_PUB) && out_free;
		case (state_q)
			S_SCAN: begin
				cmd.op   = OP_SCAN;
				cmd.wake = 1'b1;
			end
			S_RESCAN: cmd.op = OP_SCAN;
			S_DECIDE: cmd.op = OP_DECIDE;
			S_COMMIT: cmd.op = OP_COMMIT;
			S_DIV:    cmd.op = OP_DIV;
			S_CREATE: cmd.op = OP_CREATE;
			S_EXEC: begin
				case (code_q)
					CMD_FINISH: cmd.op = OP_FINISH;
					CMD_LOCK:   cmd.op = OP_LOCK;
					CMD_UNLOCK: cmd.op = OP_UNLOCK;
					default:    cmd.op = OP_NONE;
				endcase
			end
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule

### src/rms_dpath.sv
// ----------------------------------------------------------------------------
// rms_dpath
// Slot tables, wake and pick scan, switch decision and remainder divider.
// ----------------------------------------------------------------------------
module rms_dpath import rms_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [CMD_W-1:0]     in_cmd,
	input  logic [SLOT_W-1:0]    in_slot,
	input  logic [TIME_IN_W-1:0] in_budget,
	input  logic [TIME_IN_W-1:0] in_period,
	input  logic [PRIO_W-1:0]    in_ceiling,
	output logic                 switch_needed,
	output logic [SLOT_W-1:0]    running_slot
);
	localparam int SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int TW   = TIME_BITS;
	localparam int IDLE = NUM_SLOTS - 1;

	// Slot tables
	logic [TW-1:0]     per_q  [NUM_SLOTS];
	logic [TW-1:0]     bud_q  [NUM_SLOTS];
	logic [TW-1:0]     rem_q  [NUM_SLOTS];
	logic [TW:0]       run_q  [NUM_SLOTS];
	logic [PRIO_W-1:0] bp_q   [NUM_SLOTS];
	logic [PRIO_W-1:0] cp_q   [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] done_q;
	logic [NUM_SLOTS-1:0] runnable_q;

	logic [TICK_W-1:0] tick_q;
	logic [SW-1:0]     cur_q;
	logic [SW-1:0]     pick_q;
	logic [PRIO_W-1:0] best_cp_q;
	logic [PRIO_W-1:0] best_bp_q;
	logic              have_q;
	logic              sw_q;

	// Captured transaction and divider
	logic [SLOT_W-1:0] slot_q;
	logic [TW-1:0]     bud_in_q;
	logic [TW-1:0]     per_in_q;
	logic [PRIO_W-1:0] ceil_q;
	logic [TICK_W-1:0] div_q;
	logic [TW-1:0]     dr_q;
	logic              out_sw_q;
	logic [SLOT_W-1:0] out_slot_q;

	logic [SW-1:0]     addr;
	logic [TW-1:0]     a_per, a_bud, a_rem;
	logic [TW:0]       a_run;
	logic [PRIO_W-1:0] a_bp, a_cp;
	logic [TW:0]       rem_inc;
	logic              wake, eff_run, have_e, better;
	logic              idle_cur, pick_diff, over, retire;
	logic [TW:0]       sh, diff;
	logic              ge;
	logic [TW-1:0]     nr;

	// Select the table row
	always_comb begin
		case (cmd.op)
			OP_SCAN:   addr = cmd.cnt[SW-1:0];
			OP_CREATE: addr = slot_q[SW-1:0];
			default:   addr = cur_q;
		endcase
	end

	assign a_per = per_q[addr];
	assign a_bud = bud_q[addr];
	assign a_rem = rem_q[addr];
	assign a_run = run_q[addr];
	assign a_bp  = bp_q[addr];
	assign a_cp  = cp_q[addr];

	// Wake when the running remainder reaches the period, or when the tick
	// count wraps to zero; track the best key
	assign rem_inc = {1'b0, a_rem} + 1'b1;
	assign wake    = cmd.wake && (a_per != '0) &&
	                 ((rem_inc == {1'b0, a_per}) || (tick_q == '0));
	assign eff_run = runnable_q[addr] | wake;
	assign have_e  = cmd.scan_first ? 1'b0 : have_q;
	assign better  = !have_e || (a_cp < best_cp_q) ||
	                 ((a_cp == best_cp_q) && (a_bp < best_bp_q));

	// Decision on the running slot
	assign idle_cur  = (cur_q == SW'(IDLE));
	assign pick_diff = (pick_q != cur_q);
	assign over      = a_run > {1'b0, a_bud};
	assign retire    = !pick_diff && !idle_cur && (done_q[addr] || over);

	assign stat.repick       = (cmd.op == OP_DECIDE) && retire;
	assign stat.cur_runnable = runnable_q[cur_q];

	// One restoring step of tick count modulo period
	assign sh   = {dr_q, div_q[TICK_W-1]};
	assign diff = sh - {1'b0, per_in_q};
	assign ge   = sh >= {1'b0, per_in_q};
	assign nr   = ge ? diff[TW-1:0] : sh[TW-1:0];

	// Tables and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				per_q[i] <= (i == IDLE) ? TW'(1) : '0;
				bud_q[i] <= (i == IDLE) ? TW'(IDLE_BUDGET) : '0;
				rem_q[i] <= '0;
				run_q[i] <= '0;
				bp_q[i]  <= (i == IDLE) ? PRIO_W'(IDLE) : PRIO_W'(NUM_SLOTS);
				cp_q[i]  <= PRIO_W'(NUM_SLOTS);
			end
			done_q     <= '0;
			runnable_q <= {1'b1, {(NUM_SLOTS-1){1'b0}}};
			tick_q     <= '0;
			cur_q      <= SW'(IDLE);
			pick_q     <= SW'(IDLE);
			best_cp_q  <= '0;
			best_bp_q  <= '0;
			have_q     <= 1'b0;
			sw_q       <= 1'b0;
			out_sw_q   <= 1'b0;
			out_slot_q <= SLOT_W'(IDLE);
		end else begin
			if (cmd.capture) begin
				sw_q <= 1'b0;
				if (in_cmd == CMD_TICK)
					tick_q <= tick_q + 1'b1;
			end
			case (cmd.op)
				OP_SCAN: begin
					if (cmd.wake)
						rem_q[addr] <= wake ? '0 : rem_inc[TW-1:0];
					if (wake) begin
						run_q[addr]      <= '0;
						done_q[addr]     <= 1'b0;
						runnable_q[addr] <= 1'b1;
					end
					if (eff_run && better) begin
						have_q    <= 1'b1;
						pick_q    <= addr;
						best_cp_q <= a_cp;
						best_bp_q <= a_bp;
					end else begin
						have_q <= have_e;
					end
				end
				OP_DECIDE: begin
					if (pick_diff) begin
						sw_q  <= 1'b1;
						cur_q <= pick_q;
					end else if (retire) begin
						sw_q             <= 1'b1;
						runnable_q[addr] <= 1'b0;
						if (!done_q[addr])
							done_q[addr] <= 1'b1;
					end else if (!idle_cur && !done_q[addr]) begin
						run_q[addr] <= a_run + 1'b1;
					end
				end
				OP_COMMIT: cur_q <= pick_q;
				OP_CREATE: begin
					per_q[addr]      <= per_in_q;
					bud_q[addr]      <= bud_in_q;
					rem_q[addr]      <= dr_q;
					run_q[addr]      <= '0;
					bp_q[addr]       <= PRIO_W'(slot_q);
					cp_q[addr]       <= PRIO_W'(slot_q);
					done_q[addr]     <= 1'b0;
					runnable_q[addr] <= 1'b1;
				end
				OP_FINISH: done_q[addr] <= 1'b1;
				OP_LOCK:   cp_q[addr] <= ceil_q;
				OP_UNLOCK: cp_q[addr] <= a_bp;
				default: ;
			endcase
			if (cmd.publish) begin
				out_sw_q   <= sw_q;
				out_slot_q <= SLOT_W'(cur_q);
			end
		end
	end

	// Capture the transaction payload and run the divider
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q   <= in_slot;
			bud_in_q <= TW'(in_budget);
			per_in_q <= TW'(in_period);
			ceil_q   <= in_ceiling;
			div_q    <= tick_q;
			dr_q     <= '0;
		end else if (cmd.op == OP_DIV) begin
			div_q <= {div_q[TICK_W-2:0], 1'b0};
			dr_q  <= nr;
		end
	end

	assign switch_needed = out_sw_q;
	assign running_slot  = out_slot_q;
endmodule

### src/rate_monotonic_task_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// Rate monotonic scheduler over periodic task slots with priority ceiling.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  req      in   valid/ready  cmd, slot, budget, period, ceiling
//  rsp      out  valid/ready  switch_needed, running_slot
//
// One transaction at a time. A tick runs one scan of the slot table before its
// decision, and a second scan when the running slot retires (one scan of the slot
// table per pick). A create runs the divider (one quotient bit per cycle of tick count
// modulo period); finish, lock and unlock run one execute step, others publish at once.
// Reset loads the slot tables at once. A stalled response holds the block
// in its publish step; the next request is taken once the response is queued.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler import rms_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	rms_req_if.sink     req,
	rms_rsp_if.source   rsp
);
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	rms_ctrl #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_cmd    (req.cmd),
		.in_slot   (req.slot),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	rms_dpath #(
		.NUM_SLOTS (NUM_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.in_cmd        (req.cmd),
		.in_slot       (req.slot),
		.in_budget     (req.budget),
		.in_period     (req.period),
		.in_ceiling    (req.ceiling),
		.switch_needed (rsp.switch_needed),
		.running_slot  (rsp.running_slot)
	);

`ifndef SYNTH
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a transaction is in flight");
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.publish |=> rsp.valid)
		else $error("published response not presented");
	a_cur_runnable: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.publish |-> dp_stat.cur_runnable)
		else $error("running slot is not runnable");
`endif
endmodule

### tb/sv/rms_sched_checker.sv
// ----------------------------------------------------------------------------
// rms_sched_checker
// Watches the request and response channels of the scheduler, keeps its own
// copy of the slot tables, predicts each response and compares it.
// ----------------------------------------------------------------------------
module rms_sched_checker import rms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rms_req_if.sink  req_mon,
	rms_rsp_if.sink  rsp_mon,
	output int       fail_count,
	output int       pending
);
	localparam int NS   = NUM_SLOTS_DEF;
	localparam int IDLE = NS - 1;

	typedef struct packed {
		logic              sw;
		logic [SLOT_W-1:0] slot;
	} sched_rsp_t;

	logic [TICK_W-1:0]      ticks;
	logic [TIME_BITS_DEF-1:0] per [NS];
	logic [TIME_BITS_DEF-1:0] bud [NS];
	logic [PRIO_W-1:0]      base_p [NS];
	logic [PRIO_W-1:0]      cur_p [NS];
	logic [16:0]            used [NS];
	logic [NS-1:0]          done;
	logic [NS-1:0]          ready_set;
	logic [SLOT_W-1:0]      running;
	sched_rsp_t             expected_q[$];

	assign pending = expected_q.size();

	// Lowest current priority wins, ties to lower base priority
	function automatic logic [SLOT_W-1:0] best_slot();
		logic [SLOT_W-1:0] b;
		b = SLOT_W'(IDLE);
		for (int i = 0; i < NS; i++)
			if (ready_set[i]) begin
				if (cur_p[i] < cur_p[b])
					b = SLOT_W'(i);
				else if (cur_p[i] == cur_p[b] && base_p[i] < base_p[b])
					b = SLOT_W'(i);
			end
		return b;
	endfunction

	task automatic sched_tick(output logic sw);
		logic [SLOT_W-1:0] p;
		logic [SLOT_W-1:0] c;
		ticks = ticks + 1;
		for (int i = 0; i < NS; i++)
			if (per[i] != 0 && (ticks % per[i]) == 0) begin
				used[i] = 0;
				done[i] = 0;
				ready_set[i] = 1;
			end
		p = best_slot();
		c = running;
		sw = 0;
		if (p != c)
			sw = 1;
		else if (done[c]) begin
			if (c != IDLE) begin
				ready_set[c] = 0;
				sw = 1;
			end
		end else if (used[c] <= {1'b0, bud[c]}) begin
			if (c != IDLE)
				used[c] = used[c] + 17'd1;
		end else if (c != IDLE) begin
			ready_set[c] = 0;
			done[c] = 1;
			sw = 1;
		end
		if (sw)
			running = best_slot();
	endtask

	task automatic apply_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] s,
			input logic [15:0] b, input logic [15:0] pd, input logic [PRIO_W-1:0] ceil);
		sched_rsp_t r;
		logic sw;
		sw = 0;
		case (cmd)
			CMD_TICK: sched_tick(sw);
			CMD_CREATE: begin
				if (s < IDLE) begin
					bud[s] = b;
					per[s] = pd;
					base_p[s] = PRIO_W'(s);
					cur_p[s] = PRIO_W'(s);
					done[s] = 0;
					used[s] = 0;
					ready_set[s] = 1;
				end
			end
			CMD_FINISH: done[running] = 1;
			CMD_LOCK: cur_p[running] = ceil;
			CMD_UNLOCK: cur_p[running] = base_p[running];
			default: ;
		endcase
		r.sw = sw;
		r.slot = running;
		expected_q.push_back(r);
	endtask

	// Reset the model, then predict on each request and compare each response
	always @(posedge clk or negedge arst_n) begin
		sched_rsp_t e;
		if (!arst_n) begin
			ticks = 0;
			for (int i = 0; i < NS; i++) begin
				per[i] = 0;
				bud[i] = 0;
				base_p[i] = PRIO_W'(NS);
				cur_p[i] = PRIO_W'(NS);
				used[i] = 0;
			end
			per[IDLE] = 1;
			bud[IDLE] = TIME_BITS_DEF'(IDLE_BUDGET);
			base_p[IDLE] = PRIO_W'(IDLE);
			done = '0;
			ready_set = '0;
			ready_set[IDLE] = 1;
			running = SLOT_W'(IDLE);
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (req_mon.valid && req_mon.ready)
				apply_cmd(req_mon.cmd, req_mon.slot, req_mon.budget, req_mon.period,
					req_mon.ceiling);
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response transaction");
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (rsp_mon.switch_needed !== e.sw) begin
						$error("switch_needed: expected %0d, got %0d", e.sw,
							rsp_mon.switch_needed);
						fail_count++;
					end
					if (rsp_mon.running_slot !== e.slot) begin
						$error("running_slot: expected %0d, got %0d", e.slot,
							rsp_mon.running_slot);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives scheduler commands: directed corners, then random task sets with
// tick runs, random gaps and response stalls. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import rms_pkg::*;;
	localparam int LIMIT = 1500000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   stall_left;
	bit   long_hold;

	rms_req_if req ();
	rms_rsp_if rsp ();

	rate_monotonic_task_scheduler dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	rms_sched_checker chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending));

	always begin
		clk = 0;
		#10;
		clk = 1;
		#10;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	// Send one transaction, wait for acceptance, then idle a random gap if gaps is set
	task automatic send(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [15:0] b, input logic [15:0] p, input logic [PRIO_W-1:0] ce,
			input bit gaps);
		int g;
		req.valid <= 1;
		req.cmd <= c;
		req.slot <= s;
		req.budget <= b;
		req.period <= p;
		req.ceiling <= ce;
		do @(posedge clk); while (!req.ready);
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic rand_item(input bit gaps);
		logic [CMD_W-1:0] c;
		logic [15:0] b;
		logic [15:0] p;
		int k;
		k = $urandom_range(0, 99);
		c = k < 55 ? CMD_TICK : k < 67 ? CMD_CREATE : k < 77 ? CMD_FINISH :
			k < 86 ? CMD_LOCK : k < 95 ? CMD_UNLOCK : 3'($urandom_range(5, 7));
		b = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8));
		p = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12));
		send(c, 5'($urandom), b, p, 6'($urandom), gaps);
	endtask

	// Response side: short random stalls, an occasional long one, and one
	// long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 0;
			stall_left <= 0;
		end else if (long_hold) begin
			rsp.ready <= 0;
		end else if (stall_left > 0) begin
			rsp.ready  <= 0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 49) == 0) begin
			rsp.ready  <= 0;
			stall_left <= $urandom_range(10, 60);
		end else begin
			rsp.ready <= ($urandom_range(0, 9) < 7);
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("rate_monotonic_task_scheduler: mismatch");
			$finish;
		end
	end

	initial begin
		long_hold = 0;
		arst_n = 0;
		req.valid = 0;
		req.cmd = CMD_TICK;
		req.slot = 0;
		req.budget = 0;
		req.period = 0;
		req.ceiling = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed corners
		send(CMD_TICK, 0, 0, 0, 0, 0);
		send(CMD_CREATE, 0, 16'hFFFF, 16'hFFFF, 0, 0);
		send(CMD_CREATE, 30, 0, 1, 0, 0);
		send(CMD_CREATE, 31, 5, 5, 0, 0);
		send(CMD_CREATE, 5, 2, 0, 0, 0);
		send(CMD_TICK, 0, 0, 0, 0, 0);
		send(CMD_TICK, 0, 0, 0, 0, 0);
		send(CMD_LOCK, 0, 0, 0, 6'd63, 0);
		send(CMD_TICK, 0, 0, 0, 0, 0);
		send(CMD_LOCK, 0, 0, 0, 6'd0, 0);
		send(CMD_UNLOCK, 0, 0, 0, 0, 0);
		send(CMD_FINISH, 0, 0, 0, 0, 0);
		send(CMD_TICK, 0, 0, 0, 0, 0);
		send(CMD_FINISH, 0, 0, 0, 0, 0);
		send(CMD_TICK, 0, 0, 0, 0, 0);
		send(3'd5, 0, 0, 0, 0, 0);
		send(3'd7, 5'h1F, 16'hFFFF, 16'hFFFF, 6'h3F, 0);
		repeat (6) send(CMD_TICK, 0, 0, 0, 0, 0);
		send(CMD_CREATE, 30, 16'hAAAA, 16'h5555, 6'h2A, 0);

		// Long receiver hold while requests keep coming
		long_hold = 1;
		fork
			repeat (400) @(posedge clk);
			repeat (8) rand_item(0);
		join_any
		long_hold = 0;
		wait fork;

		// Random part
		for (int n = 0; n < 1700; n++) begin
			rand_item(1);
			if (n == 800) begin
				req.valid <= 0;
				while (pending != 0) @(posedge clk);
			end
		end
		req.valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("rate_monotonic_task_scheduler: match");
		else
			$display("rate_monotonic_task_scheduler: mismatch");
		$finish;
	end
endmodule

### files.f
src/rms_pkg.sv
src/rms_req_if.sv
src/rms_rsp_if.sv
src/rms_ctrl.sv
src/rms_dpath.sv
src/rate_monotonic_task_scheduler.sv
tb/sv/rms_sched_checker.sv
tb/sv/tb_top.sv
